// ----- rtl/tcq_pkg.sv -----
package tcq_pkg;

  localparam int CLIENTS   = 64;
  localparam int SLOTS     = 16;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int DEPTH     = CLIENTS * SLOTS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CLIENT_AW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_GET    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOTHING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  client;
    logic [7:0]  cmd_code;
    logic [31:0] delay;
    logic [31:0] payload;
    logic [31:0] handle;
    logic [31:0] now;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_code;
    logic [31:0] out_payload;
    logic [31:0] out_handle;
  } out_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [31:0] deadline;
    logic [31:0] payload;
    logic [31:0] handle;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [ADDR_W-1:0] slot_addr(logic [5:0] client, logic [CNT_W-1:0] idx);
    slot_addr = ADDR_W'(int'(client) * SLOTS + int'(idx));
  endfunction

endpackage

// ----- rtl/tcq_ram.sv -----
module tcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/timed_command_queue.sv -----
// timed_command_queue: one insertion-ordered queue of delayed commands per client
//
// input channel: in_valid_i / in_stall_o / in_word_i carry one command word
// (add, get expired, remove by code, clear). output channel: out_valid_o /
// out_stall_i / out_word_o carry exactly one result word per command.
// a word moves at a clock edge with valid high and stall low.
//
// one command at a time. add and clear pass from accept through S_LEN to
// S_DONE; get and remove also scan the client's queue (at most 16 entries)
// in S_SCAN, paced by the single read port of the slot memory: the scan
// reads one slot a cycle and writes the compacted entry back behind it.
// in_stall_o is high from accept until the result is placed in the output
// register, so a new command is taken while the previous result still waits.
//
// reset clears the per-client length valid bits, so every queue reads empty;
// no clearing pass is needed. if the receiver stalls, the result holds in the
// output register and a finished command waits until that register frees up.
module timed_command_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tcq_pkg::in_t  in_word_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tcq_pkg::out_t out_word_o
);

  tcq_pkg::state_e state_q, state_d;
  tcq_pkg::in_t    item_q;
  tcq_pkg::out_t   res_q, res_d;
  tcq_pkg::out_t   out_word_q;
  logic            out_valid_q;

  logic [tcq_pkg::CNT_W-1:0] len_q, len_d;
  logic [tcq_pkg::CNT_W-1:0] rd_q, rd_d;
  logic [tcq_pkg::CNT_W-1:0] wr_q, wr_d;
  logic                      rvalid_q, rvalid_d;
  logic                      found_q, found_d;
  logic [tcq_pkg::CLIENTS-1:0] len_vld_q, len_vld_d;

  // slot memory ports
  logic                       slot_we, slot_re;
  logic [tcq_pkg::ADDR_W-1:0] slot_waddr, slot_raddr;
  tcq_pkg::entry_t            slot_wdata, slot_rdata;

  // length memory ports
  logic                          len_we, len_re;
  logic [tcq_pkg::CLIENT_AW-1:0] len_waddr, len_raddr;
  logic [tcq_pkg::CNT_W-1:0]     len_wdata, len_rdata;

  logic                          accept, client_ok, out_free, scan_end, drop;
  logic [tcq_pkg::CLIENT_AW-1:0] cl_idx;
  logic [tcq_pkg::CNT_W-1:0]     len_cur;

  tcq_ram #(.WIDTH(tcq_pkg::ENTRY_W), .DEPTH(tcq_pkg::DEPTH)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  tcq_ram #(.WIDTH(tcq_pkg::CNT_W), .DEPTH(tcq_pkg::CLIENTS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (len_waddr),
    .wdata_i (len_wdata),
    .re_i    (len_re),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  assign in_stall_o  = (state_q != tcq_pkg::S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign client_ok = int'(item_q.client) < tcq_pkg::CLIENTS;
  assign cl_idx    = tcq_pkg::CLIENT_AW'(item_q.client);
  // a length never written reads as an empty queue
  assign len_cur   = (client_ok && len_vld_q[cl_idx]) ? len_rdata : '0;
  assign scan_end  = !rvalid_q && (rd_q == len_q);

  // get drops only the first due entry, remove drops every matching one
  always_comb begin
    if (tcq_pkg::opcode_e'(item_q.opcode) == tcq_pkg::OP_GET) begin
      drop = !found_q && (slot_rdata.deadline < item_q.now);
    end else begin
      drop = (slot_rdata.code == item_q.cmd_code);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcq_pkg::S_IDLE: begin
        if (accept) begin
          state_d = tcq_pkg::S_LEN;
        end
      end
      tcq_pkg::S_LEN: begin
        if (client_ok && (tcq_pkg::opcode_e'(item_q.opcode) == tcq_pkg::OP_GET ||
                          tcq_pkg::opcode_e'(item_q.opcode) == tcq_pkg::OP_REMOVE)) begin
          state_d = tcq_pkg::S_SCAN;
        end else begin
          state_d = tcq_pkg::S_DONE;
        end
      end
      tcq_pkg::S_SCAN: begin
        if (scan_end) begin
          state_d = tcq_pkg::S_DONE;
        end
      end
      tcq_pkg::S_DONE: begin
        if (out_free) begin
          state_d = tcq_pkg::S_IDLE;
        end
      end
      default: state_d = tcq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    res_d      = res_q;
    len_d      = len_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    rvalid_d   = 1'b0;
    found_d    = found_q;
    len_vld_d  = len_vld_q;
    slot_we    = 1'b0;
    slot_re    = 1'b0;
    slot_waddr = tcq_pkg::slot_addr(item_q.client, wr_q);
    slot_raddr = tcq_pkg::slot_addr(item_q.client, rd_q);
    slot_wdata = slot_rdata;
    len_we     = 1'b0;
    len_re     = 1'b0;
    len_waddr  = cl_idx;
    len_raddr  = tcq_pkg::CLIENT_AW'(in_word_i.client);
    len_wdata  = wr_q;

    unique case (state_q)
      tcq_pkg::S_IDLE: begin
        len_re = accept;
      end
      tcq_pkg::S_LEN: begin
        res_d   = '0;
        len_d   = len_cur;
        rd_d    = '0;
        wr_d    = '0;
        found_d = 1'b0;
        unique case (tcq_pkg::opcode_e'(item_q.opcode))
          tcq_pkg::OP_ADD: begin
            if (!client_ok || int'(len_cur) >= tcq_pkg::SLOTS) begin
              res_d.status = tcq_pkg::ST_FULL;
            end else begin
              slot_we             = 1'b1;
              slot_waddr          = tcq_pkg::slot_addr(item_q.client, len_cur);
              slot_wdata.code     = item_q.cmd_code;
              slot_wdata.deadline = item_q.now + item_q.delay;
              slot_wdata.payload  = item_q.payload;
              slot_wdata.handle   = item_q.handle;
              len_we              = 1'b1;
              len_wdata           = len_cur + 1'b1;
              len_vld_d[cl_idx]   = 1'b1;
            end
          end
          tcq_pkg::OP_GET: begin
            res_d.status = tcq_pkg::ST_NOTHING;
          end
          tcq_pkg::OP_REMOVE: begin
          end
          tcq_pkg::OP_CLEAR: begin
            if (client_ok) begin
              len_we            = 1'b1;
              len_wdata         = '0;
              len_vld_d[cl_idx] = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      tcq_pkg::S_SCAN: begin
        // issue the next slot read
        if (rd_q != len_q) begin
          slot_re  = 1'b1;
          rd_d     = rd_q + 1'b1;
          rvalid_d = 1'b1;
        end
        // handle the slot read last cycle; kept entries are packed at wr
        if (rvalid_q) begin
          if (drop) begin
            if (tcq_pkg::opcode_e'(item_q.opcode) == tcq_pkg::OP_GET) begin
              found_d           = 1'b1;
              res_d.status      = tcq_pkg::ST_OK;
              res_d.out_code    = slot_rdata.code;
              res_d.out_payload = slot_rdata.payload;
              res_d.out_handle  = slot_rdata.handle;
            end
          end else begin
            slot_we = 1'b1;
            wr_d    = wr_q + 1'b1;
          end
        end
        if (scan_end) begin
          len_we    = 1'b1;
          len_wdata = wr_q;
        end
      end
      tcq_pkg::S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcq_pkg::S_IDLE;
      rvalid_q    <= 1'b0;
      len_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rvalid_q  <= rvalid_d;
      len_vld_q <= len_vld_d;
      if (state_q == tcq_pkg::S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_word_i;
    end
    if (state_q == tcq_pkg::S_DONE && out_free) begin
      out_word_q <= res_q;
    end
    res_q   <= res_d;
    len_q   <= len_d;
    rd_q    <= rd_d;
    wr_q    <= wr_d;
    found_q <= found_d;
  end

endmodule
